// ----- src/bpc_pkg.sv -----
// Shared types, constants and helpers for the pressure compensation pipeline.
package bpc_pkg;

    localparam int DIV_W     = 32;
    localparam int DIV_STEPS = 32;
    localparam int SIDE_W    = 64;

    typedef enum logic [2:0] {
        REG_OSS   = 3'd0,
        REG_AC123 = 3'd1,
        REG_AC456 = 3'd2,
        REG_B12   = 3'd3,
        REG_MCMD  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  oss;
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
    } coef_t;

    typedef struct packed {
        logic               valid;
        logic               zero;
        logic signed [31:0] temp;
        logic signed [31:0] b6;
        logic [23:0]        up;
    } temp_word_t;

    typedef struct packed {
        logic               valid;
        logic               status;
        logic signed [31:0] temp;
        logic signed [31:0] pres;
    } res_word_t;

    function automatic logic signed [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [31:0] tdiv_p2(input logic signed [31:0] a,
                                                   input logic [4:0] k);
        logic [31:0] bias;
        bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return (a + $signed(bias)) >>> k;
    endfunction

endpackage

// ----- src/bpc_div.sv -----
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bpc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [bpc_pkg::DIV_W-1:0]   dividend,
    input  logic [bpc_pkg::DIV_W-1:0]   divisor,
    input  logic [bpc_pkg::SIDE_W-1:0]  in_side,
    output logic                        out_valid,
    output logic [bpc_pkg::DIV_W-1:0]   quotient,
    output logic [bpc_pkg::SIDE_W-1:0]  out_side
);
    import bpc_pkg::*;

    logic              vld_reg  [DIV_STEPS];
    logic [DIV_W-1:0]  rem_reg  [DIV_STEPS];
    logic [DIV_W-1:0]  num_reg  [DIV_STEPS];
    logic [DIV_W-1:0]  den_reg  [DIV_STEPS];
    logic [SIDE_W-1:0] side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic              v_in;
        logic [DIV_W-1:0]  rem_in;
        logic [DIV_W-1:0]  num_in;
        logic [DIV_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DIV_W:0]    trial;
        logic              ge;
        logic [DIV_W:0]    diff;
        logic [DIV_W-1:0]  rem_next;
        logic [DIV_W-1:0]  num_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign num_in  = dividend;
            assign den_in  = divisor;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial    = {rem_in, num_in[DIV_W-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        assign num_next = {num_in[DIV_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quotient  = num_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

// ----- src/bpc_temp.sv -----
// Temperature half: b5, temperature and b6, with the signed md divide.
module bpc_temp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [15:0]         raw_temperature,
    input  logic [23:0]         raw_pressure,
    input  bpc_pkg::coef_t      coef,
    output bpc_pkg::temp_word_t tw
);
    import bpc_pkg::*;

    // stage 1
    logic               s1_v_reg;
    logic [31:0]        s1_prod_reg;
    logic [23:0]        s1_up_reg;
    logic signed [16:0] d17;
    logic signed [33:0] prod34;

    // stage 2
    logic               s2_v_reg;
    logic signed [31:0] s2_x1_reg;
    logic signed [31:0] s2_den_reg;
    logic signed [31:0] s2_num_reg;
    logic [23:0]        s2_up_reg;
    logic signed [31:0] x1_next;

    // divider
    logic               neg;
    logic [31:0]        num_abs;
    logic [31:0]        den_abs;
    logic [SIDE_W-1:0]  side_in;
    logic               dv_valid;
    logic [31:0]        dv_quo;
    logic [SIDE_W-1:0]  dv_side;

    // stage 3
    logic signed [31:0] q_s;
    logic signed [31:0] x2;
    logic signed [31:0] b5;
    temp_word_t         tw_reg;
    temp_word_t         tw_next;

    assign d17    = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.ac6});
    assign prod34 = d17 * $signed({1'b0, coef.ac5});
    assign x1_next = tdiv_p2($signed(s1_prod_reg), 5'd15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            tw_reg   <= '0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            tw_reg   <= tw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= prod34[31:0];
            s1_up_reg   <= raw_pressure >> (4'd8 - {2'b00, coef.oss});
            s2_x1_reg   <= x1_next;
            s2_den_reg  <= x1_next + sx16(coef.md);
            s2_num_reg  <= sx16(coef.mc) <<< 11;
            s2_up_reg   <= s1_up_reg;
        end
    end

    assign neg     = s2_num_reg[31] ^ s2_den_reg[31];
    assign num_abs = s2_num_reg[31] ? 32'd0 - s2_num_reg : s2_num_reg;
    assign den_abs = s2_den_reg[31] ? 32'd0 - s2_den_reg : s2_den_reg;
    assign side_in = {6'd0, s2_up_reg, s2_x1_reg, neg, (s2_den_reg == 32'sd0)};

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s2_v_reg),
        .dividend (num_abs),
        .divisor  (den_abs),
        .in_side  (side_in),
        .out_valid(dv_valid),
        .quotient (dv_quo),
        .out_side (dv_side)
    );

    assign q_s = $signed(dv_quo);
    assign x2  = dv_side[1] ? -q_s : q_s;
    assign b5  = $signed(dv_side[33:2]) + x2;

    always_comb
    begin
        tw_next.valid = dv_valid;
        tw_next.zero  = dv_side[0];
        tw_next.temp  = tdiv_p2(b5 + 32'sd8, 5'd4);
        tw_next.b6    = b5 - 32'sd4000;
        tw_next.up    = dv_side[57:34];
    end

    assign tw = tw_reg;

endmodule

// ----- src/bpc_press.sv -----
// Pressure half: b3, b4, b7, the unsigned divide and the final correction.
module bpc_press (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  bpc_pkg::temp_word_t tw,
    input  bpc_pkg::coef_t      coef,
    output bpc_pkg::res_word_t  res
);
    import bpc_pkg::*;

    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg, p7_v_reg;
    logic p8_v_reg, p9_v_reg, p10_v_reg;

    // temperature and zero flag ride alongside up to the divider
    logic signed [31:0] t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic               z1_reg, z2_reg, z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic [23:0]        u1_reg, u2_reg, u3_reg, u4_reg, u5_reg;

    logic signed [31:0] p1_sq_reg, p1_a2_reg, p1_a3_reg;
    logic signed [31:0] p2_sq_reg, p2_x2a_reg, p2_x1c_reg;
    logic signed [31:0] p3_b2sq_reg, p3_b1sq_reg, p3_x2a_reg, p3_x1c_reg;
    logic signed [31:0] p4_b3pre_reg, p4_xsum_reg;
    logic signed [31:0] p5_b3_reg;
    logic [31:0]        p5_u_reg;
    logic [31:0]        p6_b4p_reg, p6_b7_reg;
    logic [31:0]        p7_dvd_reg, p7_b4_reg;
    logic               p7_fix_reg;

    logic [31:0]        b4_next;
    logic signed [31:0] b3s, x3b;

    logic               dv_valid;
    logic [31:0]        dv_quo;
    logic [SIDE_W-1:0]  dv_side;
    logic [SIDE_W-1:0]  side_in;

    logic signed [31:0] p8_p_reg, p8_t_reg;
    logic               p8_z_reg;
    logic [31:0]        q_next;
    logic signed [31:0] p9_p_reg, p9_xsq_reg, p9_m2_reg, p9_t_reg;
    logic               p9_z_reg;
    logic signed [31:0] x1_p;
    logic signed [31:0] p10_p_reg, p10_m1_reg, p10_m2_reg, p10_t_reg;
    logic               p10_z_reg;
    logic signed [31:0] x3_f;

    res_word_t          res_reg;

    assign b3s     = tdiv_p2((p4_b3pre_reg <<< coef.oss) + 32'sd2, 5'd2);
    assign x3b     = tdiv_p2(p4_xsum_reg + 32'sd2, 5'd2);
    assign b4_next = p6_b4p_reg >> 15;
    assign side_in = {30'd0, t7_reg, z7_reg, p7_fix_reg};
    assign q_next  = dv_side[0] ? {dv_quo[30:0], 1'b0} : dv_quo;
    assign x1_p    = tdiv_p2(p8_p_reg, 5'd8);
    assign x3_f    = tdiv_p2(tdiv_p2(p10_m1_reg, 5'd16) + tdiv_p2(p10_m2_reg, 5'd16)
                             + 32'sd3791, 5'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            p6_v_reg  <= 1'b0;
            p7_v_reg  <= 1'b0;
            p8_v_reg  <= 1'b0;
            p9_v_reg  <= 1'b0;
            p10_v_reg <= 1'b0;
            res_reg   <= '0;
        end
        else if (en)
        begin
            p1_v_reg  <= tw.valid;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= p2_v_reg;
            p4_v_reg  <= p3_v_reg;
            p5_v_reg  <= p4_v_reg;
            p6_v_reg  <= p5_v_reg;
            p7_v_reg  <= p6_v_reg;
            p8_v_reg  <= dv_valid;
            p9_v_reg  <= p8_v_reg;
            p10_v_reg <= p9_v_reg;
            // output
            res_reg.valid  <= p10_v_reg;
            res_reg.status <= p10_z_reg;
            res_reg.temp   <= p10_z_reg ? 32'sd0 : p10_t_reg;
            res_reg.pres   <= p10_z_reg ? 32'sd0 : p10_p_reg + x3_f;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // P1
            p1_sq_reg <= tw.b6 * tw.b6;
            p1_a2_reg <= sx16(coef.ac2) * tw.b6;
            p1_a3_reg <= sx16(coef.ac3) * tw.b6;
            t1_reg <= tw.temp;
            z1_reg <= tw.zero;
            u1_reg <= tw.up;
            // P2
            p2_sq_reg  <= tdiv_p2(p1_sq_reg, 5'd12);
            p2_x2a_reg <= tdiv_p2(p1_a2_reg, 5'd11);
            p2_x1c_reg <= tdiv_p2(p1_a3_reg, 5'd13);
            t2_reg <= t1_reg;
            z2_reg <= z1_reg;
            u2_reg <= u1_reg;
            // P3
            p3_b2sq_reg <= sx16(coef.b2) * p2_sq_reg;
            p3_b1sq_reg <= sx16(coef.b1) * p2_sq_reg;
            p3_x2a_reg  <= p2_x2a_reg;
            p3_x1c_reg  <= p2_x1c_reg;
            t3_reg <= t2_reg;
            z3_reg <= z2_reg;
            u3_reg <= u2_reg;
            // P4
            p4_b3pre_reg <= (sx16(coef.ac1) <<< 2) + tdiv_p2(p3_b2sq_reg, 5'd11)
                            + p3_x2a_reg;
            p4_xsum_reg  <= p3_x1c_reg + tdiv_p2(p3_b1sq_reg, 5'd16);
            t4_reg <= t3_reg;
            z4_reg <= z3_reg;
            u4_reg <= u3_reg;
            // P5
            p5_b3_reg <= b3s;
            p5_u_reg  <= x3b + 32'd32768;
            t5_reg <= t4_reg;
            z5_reg <= z4_reg;
            u5_reg <= u4_reg;
            // P6
            p6_b4p_reg <= {16'd0, coef.ac4} * p5_u_reg;
            p6_b7_reg  <= ({8'd0, u5_reg} - p5_b3_reg) * (32'd50000 >> coef.oss);
            t6_reg <= t5_reg;
            z6_reg <= z5_reg;
            // P7
            p7_b4_reg  <= b4_next;
            p7_fix_reg <= p6_b7_reg[31];
            p7_dvd_reg <= p6_b7_reg[31] ? p6_b7_reg : {p6_b7_reg[30:0], 1'b0};
            t7_reg <= t6_reg;
            z7_reg <= z6_reg | (b4_next == 32'd0);
            // P8
            p8_p_reg <= $signed(q_next);
            p8_t_reg <= $signed(dv_side[33:2]);
            p8_z_reg <= dv_side[1];
            // P9
            p9_xsq_reg <= x1_p * x1_p;
            p9_m2_reg  <= -32'sd7357 * p8_p_reg;
            p9_p_reg   <= p8_p_reg;
            p9_t_reg   <= p8_t_reg;
            p9_z_reg   <= p8_z_reg;
            // P10
            p10_m1_reg <= p9_xsq_reg * 32'sd3038;
            p10_m2_reg <= p9_m2_reg;
            p10_p_reg  <= p9_p_reg;
            p10_t_reg  <= p9_t_reg;
            p10_z_reg  <= p9_z_reg;
        end
    end

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (p7_v_reg),
        .dividend (p7_dvd_reg),
        .divisor  (p7_b4_reg),
        .in_side  (side_in),
        .out_valid(dv_valid),
        .quotient (dv_quo),
        .out_side (dv_side)
    );

    assign res = res_reg;

endmodule

// ----- src/barometric_pressure_compensation.sv -----
// Top level: configuration registers, pipeline control and the two halves.
//
// Input channel: raw_temperature and raw_pressure with in_valid/in_stall; a word
// is taken at a clock edge with in_valid high and in_stall low.
// Output channel: temperature_tenths, pressure_pa and status with
// out_valid/out_stall; a word leaves at an edge with out_valid high and
// out_stall low. status high means a divisor was zero; both values are then 0.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while no word is in flight.
// The path from input to output runs through two 32-stage divider pipes (md
// term and b4) plus 14 arithmetic stages. One word per cycle is sustained unless the output stalls.
// While out_valid is high and out_stall is high the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
// Reset clears all valid bits and all configuration registers to zero.
module barometric_pressure_compensation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        raw_temperature,
    input  logic [23:0]        raw_pressure,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] temperature_tenths,
    output logic signed [31:0] pressure_pa,
    output logic               status,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import bpc_pkg::*;

    coef_t      coef_reg;
    logic       adv;
    temp_word_t tw;
    res_word_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OSS:
                begin
                    coef_reg.oss <= cfg_data[1:0];
                end
                REG_AC123:
                begin
                    coef_reg.ac1 <= cfg_data[47:32];
                    coef_reg.ac2 <= cfg_data[31:16];
                    coef_reg.ac3 <= cfg_data[15:0];
                end
                REG_AC456:
                begin
                    coef_reg.ac4 <= cfg_data[47:32];
                    coef_reg.ac5 <= cfg_data[31:16];
                    coef_reg.ac6 <= cfg_data[15:0];
                end
                REG_B12:
                begin
                    coef_reg.b1 <= cfg_data[31:16];
                    coef_reg.b2 <= cfg_data[15:0];
                end
                REG_MCMD:
                begin
                    coef_reg.mc <= cfg_data[31:16];
                    coef_reg.md <= cfg_data[15:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign adv      = !(res.valid && out_stall);
    assign in_stall = !adv;

    bpc_temp u_temp (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_valid       (in_valid),
        .raw_temperature(raw_temperature),
        .raw_pressure   (raw_pressure),
        .coef           (coef_reg),
        .tw             (tw)
    );

    bpc_press u_press (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (adv),
        .tw   (tw),
        .coef (coef_reg),
        .res  (res)
    );

    assign out_valid          = res.valid;
    assign temperature_tenths = res.temp;
    assign pressure_pa        = res.pres;
    assign status             = res.status;

    a_zero_results: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> temperature_tenths == 32'sd0 && pressure_pa == 32'sd0)
        else $error("status set with nonzero results");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid)
        else $error("output word lost during stall");

    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(pressure_pa))
        else $error("pipeline advanced under stall");

endmodule

// ----- verif/tb.sv -----
// Testbench for the pressure compensation block: random and directed words against a scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpc_pkg::*;

    typedef struct {
        logic signed [31:0] temp;
        logic signed [31:0] pres;
        logic               status;
    } comp_t;

    int unsigned n_errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    class comp_scoreboard;
        logic [1:0]  oss;
        logic [47:0] ac123, ac456;
        logic [31:0] b12, mcmd;
        comp_t       pending[$];

        function void set_reg(cfg_reg_t idx, logic [47:0] v);
            case (idx)
                REG_OSS:   oss = v[1:0];
                REG_AC123: ac123 = v;
                REG_AC456: ac456 = v;
                REG_B12:   b12 = v[31:0];
                REG_MCMD:  mcmd = v[31:0];
                default: ;
            endcase
        endfunction

        // dividend wraps to 32 bits before the truncating divide
        function logic signed [31:0] sdiv(logic signed [31:0] a, longint d);
            longint q;
            q = longint'(a) / d;
            return q[31:0];
        endfunction

        function comp_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
            comp_t r;
            longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
            logic [31:0] ac4, up, b4, b7, q, x3u, b3u;
            logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, den, tmp, p;
            logic [63:0] w;
            ac1 = $signed(ac123[47:32]); ac2 = $signed(ac123[31:16]);
            ac3 = $signed(ac123[15:0]);
            ac4 = {16'd0, ac456[47:32]}; ac5 = ac456[31:16]; ac6 = ac456[15:0];
            b1 = $signed(b12[31:16]); b2 = $signed(b12[15:0]);
            mc = $signed(mcmd[31:16]); md = $signed(mcmd[15:0]);
            ut = ut_raw;
            up = {8'd0, up_raw} >> (8 - oss);
            r.temp = 0; r.pres = 0; r.status = 1;
            w = (ut - ac6) * ac5;
            x1 = sdiv($signed(w[31:0]), 32768);
            w = longint'(x1) + md;
            den = w[31:0];
            if (den == 0) return r;
            w = mc * 2048;
            x2 = sdiv($signed(w[31:0]), den);
            b5 = x1 + x2;
            tmp = sdiv(b5 + 32'sd8, 16);
            b6 = b5 - 32'sd4000;
            sq = sdiv(b6 * b6, 4096);
            w = b2 * sq;
            x1 = sdiv($signed(w[31:0]), 2048);
            w = ac2 * b6;
            x2 = sdiv($signed(w[31:0]), 2048);
            x3 = x1 + x2;
            w = ac1 * 4 + x3;
            b3 = w[31:0];
            b3 = b3 << oss;
            b3 = sdiv(b3 + 32'sd2, 4);
            w = ac3 * b6;
            x1 = sdiv($signed(w[31:0]), 8192);
            w = b1 * sq;
            x2 = sdiv($signed(w[31:0]), 65536);
            x3 = sdiv((x1 + x2) + 32'sd2, 4);
            x3u = x3;
            b4 = (ac4 * (x3u + 32'd32768)) >> 15;
            if (b4 == 0) return r;
            b3u = b3;
            b7 = (up - b3u) * (32'd50000 >> oss);
            if (b7 < 32'h80000000) q = (b7 * 2) / b4;
            else q = (b7 / b4) * 2;
            p = q;
            x1 = sdiv(p, 256);
            x1 = x1 * x1;
            x1 = sdiv(x1 * 32'sd3038, 65536);
            x2 = sdiv(-32'sd7357 * p, 65536);
            x3 = sdiv((x1 + x2) + 32'sd3791, 16);
            r.temp = tmp; r.pres = p + x3; r.status = 0;
            return r;
        endfunction

        function void note_input(logic [15:0] ut, logic [23:0] up);
            pending.push_back(compensate(ut, up));
        endfunction

        task check_result(logic signed [31:0] t, logic signed [31:0] p, logic s);
            comp_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (s !== e.status) report_mismatch("status", s, e.status);
            if (t !== e.temp) report_mismatch("temperature_tenths", t, e.temp);
            if (p !== e.pres) report_mismatch("pressure_pa", p, e.pres);
        endtask
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [15:0]        raw_temperature = 0;
    logic [23:0]        raw_pressure = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] temperature_tenths, pressure_pa;
    logic               status;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = 0;
    logic [47:0]        cfg_data = 0;

    comp_scoreboard sb = new();
    int idle_pct = 34;

    barometric_pressure_compensation u_dut (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(temperature_tenths, pressure_pa, status);

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    task automatic write_reg(cfg_reg_t idx, logic [47:0] v);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.set_reg(idx, v);
    endtask

    // valid stays up after the accepting edge until the next word or idle
    task automatic send_word(logic [15:0] ut, logic [23:0] up);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1; raw_temperature <= ut; raw_pressure <= up;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(ut, up);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    // realistic calibration with random spread, fixed extreme values, or raw random words
    task automatic load_coefs(int kind, logic [1:0] mode);
        write_reg(REG_OSS, 48'(mode));
        if (kind == 0)
        begin
            write_reg(REG_AC123, {16'd408 + 16'($urandom_range(200)), 16'hFFCA, 16'hC692});
            write_reg(REG_AC456, {16'd32741, 16'd32757 - 16'($urandom_range(500)), 16'd23153});
            write_reg(REG_B12, 48'({16'd6190, 16'd4}));
            write_reg(REG_MCMD, 48'({16'h8001 + 16'($urandom_range(30000)), 16'd2868}));
        end
        else if (kind == 1)
        begin
            write_reg(REG_AC123, 48'hFFFF_FFFF_FFFF);
            write_reg(REG_AC456, 48'hFFFF_FFFF_FFFF);
            write_reg(REG_B12, 48'h7FFF_8000);
            write_reg(REG_MCMD, 48'h8000_7FFF);
        end
        else
        begin
            write_reg(REG_AC123, 48'({$urandom, $urandom}));
            write_reg(REG_AC456, 48'({$urandom, $urandom}));
            write_reg(REG_B12, 48'($urandom));
            write_reg(REG_MCMD, 48'($urandom));
        end
    endtask

    initial
    begin
        int n;
        repeat (2) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // registers at reset: md zero divisor
        send_word(16'd27898, 24'h5D23_00);
        send_word(16'hFFFF, 24'hFF_FFFF);
        drain();
        load_coefs(0, 2'd0);
        send_word(16'd27898, 24'd23843 << 8);
        send_word(16'd0, 24'd0);
        send_word(16'hFFFF, 24'hFFFFFF);
        send_word(16'h8000, 24'h800000);
        drain();
        load_coefs(1, 2'd3);
        send_word(16'd0, 24'hFFFFFF);
        send_word(16'hFFFF, 24'd0);
        send_word(16'h5555, 24'hAAAAAA);
        drain();
        // b4 zero: ac4 = 0
        write_reg(REG_AC456, 48'h0000_7FF5_5A71);
        send_word(16'd27898, 24'h123456);
        drain();
        // md cancels x1: ac5 = 0, md = 0
        load_coefs(0, 2'd1);
        write_reg(REG_MCMD, 48'h1234_0000);
        write_reg(REG_AC456, 48'h7FE5_0000_5A71);
        send_word(16'd1000, 24'h654321);
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            load_coefs((ph % 4 == 3) ? 2 : ((ph == 5) ? 1 : 0), ph[1:0]);
            idle_pct = (ph == 4) ? 0 : 34;
            n = 150;
            for (int i = 0; i < n; i++)
            begin
                if (ph % 4 == 3 || $urandom_range(9) == 0)
                    send_word(16'($urandom), 24'($urandom));
                else
                    send_word(16'd20000 + 16'($urandom_range(20000)),
                              24'($urandom_range(24'h9FFFFF, 24'h300000)));
                if (ph == 6 && i == 70) drain();
            end
            drain();
        end
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
